/* hw/rtl/pbs_pkg.sv */
// Types, register codes and fixed-point helpers shared by the particle bounce step block.
package pbs_pkg;

  typedef enum logic [2:0] {
    REG_GRAVITY = 3'd0,
    REG_DRAG    = 3'd1,
    REG_GROUND  = 3'd2,
    REG_SPAN    = 3'd3,
    REG_RADIUS  = 3'd4,
    REG_LIMIT   = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic signed [15:0] GravityRst = 16'sd128;
  localparam logic [8:0]         DragRst    = 9'd251;
  localparam logic [14:0]        GroundRst  = 15'd6400;
  localparam logic [14:0]        SpanRst    = 15'd10240;
  localparam logic [11:0]        RadiusRst  = 12'd80;
  localparam logic [7:0]         LimitRst   = 8'd60;

  localparam logic [9:0] HueWrap  = 10'd360;
  localparam logic [7:0] StillMax = 8'hff;

  typedef struct packed {
    logic signed [15:0] gravity_step;
    logic [8:0]         drag_factor;
    logic [14:0]        ground_level;
    logic [14:0]        screen_span;
    logic [11:0]        ball_radius;
    logic [7:0]         still_limit;
  } pbs_cfg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [7:0]         still_frames;
    logic [8:0]         hue_angle;
    logic               alive;
    logic [2:0]         bounce_rand;
  } pbs_in_t;

  typedef struct packed {
    logic signed [15:0] new_pos_x;
    logic signed [15:0] new_pos_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic [7:0]         new_still_frames;
    logic [8:0]         new_hue_angle;
    logic               new_alive;
  } pbs_out_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // v / 16 rounded toward zero
  function automatic logic signed [12:0] tdiv16(input logic signed [15:0] v);
    logic signed [16:0] t;
    t = {v[15], v} + (v[15] ? 17'sd15 : 17'sd0);
    return t[16:4];
  endfunction

  // p / 256 rounded toward zero
  function automatic logic signed [17:0] tdiv256(input logic signed [25:0] p);
    logic signed [25:0] t;
    t = p + (p[25] ? 26'sd255 : 26'sd0);
    return t[25:8];
  endfunction

  function automatic logic signed [15:0] satneg(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  // true when v / 256 truncates to zero
  function automatic logic near_zero(input logic signed [15:0] v);
    return (v >= -16'sd255) && (v <= 16'sd255);
  endfunction

  // round((2 + r) * 256 / 10), Q0.8
  function automatic logic [7:0] bounce_damp(input logic [2:0] r);
    logic [7:0] d;
    unique case (r)
      3'd0: d = 8'd51;
      3'd1: d = 8'd77;
      3'd2: d = 8'd102;
      3'd3: d = 8'd128;
      3'd4: d = 8'd154;
      3'd5: d = 8'd179;
      3'd6: d = 8'd205;
      default: d = 8'd230;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/pbs_if.sv */
// Valid/ready channel interfaces for particle items and results.
interface pbs_in_if import pbs_pkg::*;;
  logic    valid;
  logic    ready;
  pbs_in_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface pbs_out_if import pbs_pkg::*;;
  logic     valid;
  logic     ready;
  pbs_out_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

/* hw/rtl/pbs_cfg_regs.sv */
// Configuration register file with reset values and indexed writes.
module pbs_cfg_regs import pbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output pbs_cfg_t            cfg_o
);

  pbs_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_step <= GravityRst;
      cfg_q.drag_factor  <= DragRst;
      cfg_q.ground_level <= GroundRst;
      cfg_q.screen_span  <= SpanRst;
      cfg_q.ball_radius  <= RadiusRst;
      cfg_q.still_limit  <= LimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_GRAVITY: cfg_q.gravity_step <= $signed(cfg_data_i);
        REG_DRAG:    cfg_q.drag_factor  <= cfg_data_i[8:0];
        REG_GROUND:  cfg_q.ground_level <= cfg_data_i[14:0];
        REG_SPAN:    cfg_q.screen_span  <= cfg_data_i[14:0];
        REG_RADIUS:  cfg_q.ball_radius  <= cfg_data_i[11:0];
        REG_LIMIT:   cfg_q.still_limit  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/particle_bounce_step_top.sv */
// Five-stage particle update pipeline: gravity, move, still count, drag, bounce, walls, hue.
//
// Usage:
//   in_if  (sink)   : one particle per transaction, accepted when valid && ready.
//   out_if (source) : one updated particle per accepted input, in order.
//   cfg_we_i/cfg_idx_i/cfg_data_i : register write, index 0..5 in the order
//     gravity, drag, ground, span, radius, still limit; other indexes ignored.
//     Write only while no transaction is in flight.
// Each accepted input passes through the stage 1 to 5 registers to out_if. Throughput is one
// particle per clock while out_if.ready is high; the pipeline is five register stages, the two
// multiplier pairs (drag, then bounce damping with second drag) each end in a register.
// Reset clears all stage valid bits and loads the register reset values.
// When out_if.ready is low the last stage holds its result; earlier stages keep
// advancing into empty slots, so in_if.ready drops only once all five stages
// are full. Nothing is dropped or repeated on a stall.
// An inactive particle is passed through unchanged.
module particle_bounce_step_top import pbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  pbs_in_if.sink              in_if,
  pbs_out_if.source           out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pbs_cfg_t cfg;

  pbs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // ---------------- pipeline control ----------------
  logic [4:0] vld_q;
  logic [4:0] adv;

  always_comb begin
    adv[4] = !vld_q[4] || out_if.ready;
    for (int k = 3; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_if.valid;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_if.ready = adv[0];

  logic [4:0] ld;
  assign ld[0] = adv[0] && in_if.valid;
  assign ld[1] = adv[1] && vld_q[0];
  assign ld[2] = adv[2] && vld_q[1];
  assign ld[3] = adv[3] && vld_q[2];
  assign ld[4] = adv[4] && vld_q[3];

  // untouched copy of the item, used for pass-through of inactive particles
  pbs_in_t raw1_q, raw2_q, raw3_q, raw4_q, raw5_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) raw1_q <= in_if.payload;
    if (ld[1]) raw2_q <= raw1_q;
    if (ld[2]) raw3_q <= raw2_q;
    if (ld[3]) raw4_q <= raw3_q;
    if (ld[4]) raw5_q <= raw4_q;
  end

  // ---------------- stage 1: gravity, horizontal move, hue ----------------
  logic signed [15:0] px1_d, px1_q, vy1_d, vy1_q;
  logic               vxz1_d, vxz1_q;
  logic [8:0]         hue1_d, hue1_q;

  always_comb begin
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [12:0] qx;
    logic [9:0]         h;
    sy     = {in_if.payload.vel_y[15], in_if.payload.vel_y}
           + {cfg.gravity_step[15], cfg.gravity_step};
    vy1_d  = sat16({sy[16], sy});
    qx     = tdiv16(in_if.payload.vel_x);
    sx     = {in_if.payload.pos_x[15], in_if.payload.pos_x} + {{4{qx[12]}}, qx};
    px1_d  = sat16({sx[16], sx});
    vxz1_d = near_zero(in_if.payload.vel_x);
    h      = {1'b0, in_if.payload.hue_angle} + 10'd1;
    hue1_d = (h >= HueWrap) ? 9'd0 : h[8:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      px1_q  <= px1_d;
      vy1_q  <= vy1_d;
      vxz1_q <= vxz1_d;
      hue1_q <= hue1_d;
    end
  end

  // ---------------- stage 2: vertical move, still count, walls, drag products ----------
  logic signed [15:0] py2_d, py2_q, px2_d, px2_q;
  logic [7:0]         still2_d, still2_q;
  logic               alive2_d, alive2_q;
  logic [1:0]         wneg2_d, wneg2_q;
  logic signed [25:0] pdx2_d, pdx2_q, pdy2_d, pdy2_q;

  always_comb begin
    logic signed [16:0] sy;
    logic signed [12:0] qy;
    logic [7:0]         sinc;
    logic signed [15:0] rad;
    logic signed [15:0] lim;
    logic signed [15:0] pxa;
    logic               lo, hi;
    qy    = tdiv16(vy1_q);
    sy    = {raw1_q.pos_y[15], raw1_q.pos_y} + {{4{qy[12]}}, qy};
    py2_d = sat16({sy[16], sy});

    sinc = (raw1_q.still_frames == StillMax) ? StillMax : raw1_q.still_frames + 8'd1;
    if (vxz1_q && near_zero(vy1_q)) begin
      still2_d = sinc;
      alive2_d = !(sinc > cfg.still_limit);
    end else begin
      still2_d = raw1_q.still_frames;
      alive2_d = 1'b1;
    end

    rad     = $signed({4'b0, cfg.ball_radius});
    lim     = $signed({1'b0, cfg.screen_span}) - rad;
    lo      = px1_q < rad;
    pxa     = lo ? rad : px1_q;
    hi      = pxa > lim;
    px2_d   = hi ? lim : pxa;
    wneg2_d = {1'b0, lo} + {1'b0, hi};

    pdx2_d = raw1_q.vel_x * $signed({1'b0, cfg.drag_factor});
    pdy2_d = vy1_q * $signed({1'b0, cfg.drag_factor});
  end

  logic [8:0] hue2_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      py2_q    <= py2_d;
      px2_q    <= px2_d;
      still2_q <= still2_d;
      alive2_q <= alive2_d;
      wneg2_q  <= wneg2_d;
      pdx2_q   <= pdx2_d;
      pdy2_q   <= pdy2_d;
      hue2_q   <= hue1_q;
    end
  end

  // ---------------- stage 3: drag result, ground test ----------------
  logic signed [15:0] vx3_d, vx3_q, vy3_d, vy3_q, py3_d, py3_q;
  logic               bnc3_d, bnc3_q;

  always_comb begin
    logic signed [15:0] gnd;
    gnd    = $signed({1'b0, cfg.ground_level});
    vx3_d  = sat16(tdiv256(pdx2_q));
    vy3_d  = sat16(tdiv256(pdy2_q));
    bnc3_d = (vy3_d > 16'sd0) && (py2_q > gnd);
    py3_d  = bnc3_d ? gnd : py2_q;
  end

  logic signed [15:0] px3_q;
  logic [7:0]         still3_q;
  logic               alive3_q;
  logic [1:0]         wneg3_q;
  logic [8:0]         hue3_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      vx3_q    <= vx3_d;
      vy3_q    <= vy3_d;
      py3_q    <= py3_d;
      bnc3_q   <= bnc3_d;
      px3_q    <= px2_q;
      still3_q <= still2_q;
      alive3_q <= alive2_q;
      wneg3_q  <= wneg2_q;
      hue3_q   <= hue2_q;
    end
  end

  // ---------------- stage 4: bounce products ----------------
  logic signed [25:0] pby4_d, pbx4_d, pby4_q, pbx4_q;

  assign pby4_d = vy3_q * $signed({2'b0, bounce_damp(raw3_q.bounce_rand)});
  assign pbx4_d = vx3_q * $signed({1'b0, cfg.drag_factor});

  logic signed [15:0] vx4_q, vy4_q, px4_q, py4_q;
  logic               bnc4_q, alive4_q;
  logic [7:0]         still4_q;
  logic [1:0]         wneg4_q;
  logic [8:0]         hue4_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      pby4_q   <= pby4_d;
      pbx4_q   <= pbx4_d;
      vx4_q    <= vx3_q;
      vy4_q    <= vy3_q;
      px4_q    <= px3_q;
      py4_q    <= py3_q;
      bnc4_q   <= bnc3_q;
      alive4_q <= alive3_q;
      still4_q <= still3_q;
      wneg4_q  <= wneg3_q;
      hue4_q   <= hue3_q;
    end
  end

  // ---------------- stage 5: bounce velocities, wall reflection, output register ----
  pbs_out_t res5_d, res5_q;

  always_comb begin
    logic signed [17:0] qy;
    logic signed [15:0] vxb;
    logic signed [15:0] vxf;
    logic signed [15:0] vyf;
    qy  = tdiv256(pby4_q);
    vyf = bnc4_q ? sat16(-qy) : vy4_q;
    vxb = bnc4_q ? sat16(tdiv256(pbx4_q)) : vx4_q;
    // two saturating negations turn the most negative value into -32767
    unique case (wneg4_q)
      2'd0:    vxf = vxb;
      2'd1:    vxf = satneg(vxb);
      default: vxf = (vxb == 16'sh8000) ? 16'sh8001 : vxb;
    endcase
    if (raw4_q.alive) begin
      res5_d.new_pos_x        = px4_q;
      res5_d.new_pos_y        = py4_q;
      res5_d.new_vel_x        = vxf;
      res5_d.new_vel_y        = vyf;
      res5_d.new_still_frames = still4_q;
      res5_d.new_hue_angle    = hue4_q;
      res5_d.new_alive        = alive4_q;
    end else begin
      res5_d.new_pos_x        = raw4_q.pos_x;
      res5_d.new_pos_y        = raw4_q.pos_y;
      res5_d.new_vel_x        = raw4_q.vel_x;
      res5_d.new_vel_y        = raw4_q.vel_y;
      res5_d.new_still_frames = raw4_q.still_frames;
      res5_d.new_hue_angle    = raw4_q.hue_angle;
      res5_d.new_alive        = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) res5_q <= res5_d;
  end

  assign out_if.valid   = vld_q[4];
  assign out_if.payload = res5_q;

  // ---------------- assertions ----------------
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (vld_q == 5'b11111))
    else $error("input stalled while a pipeline stage is empty");

  a_inactive_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !raw5_q.alive) |->
      (out_if.payload.new_pos_x == raw5_q.pos_x &&
       out_if.payload.new_vel_y == raw5_q.vel_y &&
       out_if.payload.new_hue_angle == raw5_q.hue_angle))
    else $error("inactive particle altered");

  a_alive_never_revives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.payload.new_alive) |-> raw5_q.alive)
    else $error("inactive particle became active");

  a_hue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && raw5_q.alive) |-> (out_if.payload.new_hue_angle < 9'd360))
    else $error("hue out of range for active particle");

endmodule
